FILE: rtl/core/crrl_pkg.sv
// Shared types and codes for the client registry and resource lock unit.
package crrl_pkg;

	// Request kinds
	localparam logic [2:0] REQ_REGISTER = 3'd0;
	localparam logic [2:0] REQ_POSITION = 3'd1;
	localparam logic [2:0] REQ_ACQUIRE  = 3'd2;
	localparam logic [2:0] REQ_RELEASE  = 3'd3;

	// Result status codes
	localparam logic [3:0] STS_REGISTERED = 4'd0;
	localparam logic [3:0] STS_POS_OK     = 4'd1;
	localparam logic [3:0] STS_RESERVED   = 4'd2;
	localparam logic [3:0] STS_RELEASED   = 4'd3;
	localparam logic [3:0] STS_DUP        = 4'd4;
	localparam logic [3:0] STS_FULL       = 4'd5;
	localparam logic [3:0] STS_UNREG      = 4'd6;
	localparam logic [3:0] STS_NO_POS     = 4'd7;
	localparam logic [3:0] STS_BUSY       = 4'd8;
	localparam logic [3:0] STS_NOT_OWNER  = 4'd9;
	localparam logic [3:0] STS_ALREADY    = 4'd10;
	localparam logic [3:0] STS_BAD        = 4'd11;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_EXEC
	} ctl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic scan;
		logic exec;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;
		logic miss;
	} ctl_sts_t;

endpackage

FILE: rtl/core/crrl_ram.sv
// Generic single write port RAM with registered read.
module crrl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/crrl_ctrl.sv
// Request sequencer: capture, slot search, execute, result strobe.
module crrl_ctrl
	import crrl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd,
	output logic     busy
);

	ctl_state_t state_q, state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_n = S_LOAD;
			end
			S_LOAD: begin
				state_n = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit || sts.miss) state_n = S_EXEC;
			end
			S_EXEC: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			S_LOAD: begin
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/crrl_dp.sv
// Datapath: request registers, slot and lock tables, result registers.
module crrl_dp
	import crrl_pkg::*;
#(
	parameter int MAX_CLIENTS = 8,
	parameter int NUM_LOCKS   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	output ctl_sts_t            sts,
	input  logic [2:0]          req_type,
	input  logic [31:0]         client_addr,
	input  logic                x_present,
	input  logic signed [31:0]  x_value,
	input  logic                y_present,
	input  logic signed [31:0]  y_value,
	input  logic                res_present,
	input  logic signed [31:0]  res_number,
	output logic                done,
	output logic [3:0]          status,
	output logic [2:0]          slot_index
);

	localparam int SW  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CW  = $clog2(MAX_CLIENTS + 1);
	localparam int LW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int SXW = (SW > 3) ? SW : 3;

	// Captured request
	logic [2:0]  type_q;
	logic [31:0] addr_q;
	logic        x_ok_q, y_ok_q, res_ok_q;
	logic [31:0] x_q, y_q;
	logic [LW-1:0] lock_idx_q;

	// Search and table state
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	logic [NUM_LOCKS-1:0] held_q;

	// Result registers
	logic       done_q;
	logic [3:0] status_q;
	logic [2:0] slot_q;

	// RAM ports
	logic [31:0]   addr_rd;
	logic [SW-1:0] addr_raddr;
	logic          addr_we;
	logic          px_we, py_we;
	logic [31:0]   px_wdata, py_wdata;
	logic [SW-1:0] pos_waddr;
	logic          own_we;
	logic [SW-1:0] own_rd;

	// Execute stage decisions
	logic          full;
	logic          res_in_range;
	logic [SW-1:0] slot_cur;
	logic [SW-1:0] new_slot;
	logic          held_cur;
	logic          own_match;
	logic [3:0]    sts_n;
	logic [SW-1:0] slot_n;
	logic          set_held, clr_held;
	logic [SXW-1:0] slot_ext;

	assign slot_cur  = idx_q[SW-1:0];
	assign new_slot  = count_q[SW-1:0];
	assign full      = (count_q == CW'(MAX_CLIENTS));
	assign held_cur  = held_q[lock_idx_q];
	assign own_match = (own_rd == slot_cur);

	// Address read: slot 0 while loading, next slot while scanning
	assign addr_raddr = cmd.scan ? SW'(CW'(idx_q + 1'b1)) : '0;

	// Compare current slot against requester
	assign sts.miss = (idx_q >= count_q);
	assign sts.hit  = !sts.miss && (addr_rd == addr_q);

	// Resource number range check
	assign res_in_range = !res_number[31] && (res_number[30:0] < 31'(NUM_LOCKS));

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q     <= req_type;
			addr_q     <= client_addr;
			x_ok_q     <= x_present;
			y_ok_q     <= y_present;
			x_q        <= x_value;
			y_q        <= y_value;
			res_ok_q   <= res_present && res_in_range;
			lock_idx_q <= (res_present && res_in_range) ? res_number[LW-1:0] : '0;
		end
	end

	// Search index and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (sts.hit) begin
				found_q <= 1'b1;
			end else if (!sts.miss) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Request execution
	always_comb begin
		sts_n    = STS_BAD;
		slot_n   = slot_cur;
		addr_we  = 1'b0;
		px_we    = 1'b0;
		py_we    = 1'b0;
		px_wdata = x_q;
		py_wdata = y_q;
		pos_waddr = slot_cur;
		own_we   = 1'b0;
		set_held = 1'b0;
		clr_held = 1'b0;
		if (type_q == REQ_REGISTER) begin
			if (found_q) begin
				sts_n = STS_DUP;
			end else if (full) begin
				sts_n  = STS_FULL;
				slot_n = '0;
			end else begin
				sts_n     = STS_REGISTERED;
				slot_n    = new_slot;
				addr_we   = 1'b1;
				px_we     = 1'b1;
				py_we     = 1'b1;
				px_wdata  = '0;
				py_wdata  = '0;
				pos_waddr = new_slot;
			end
		end else if (!found_q) begin
			sts_n  = STS_UNREG;
			slot_n = '0;
		end else begin
			case (type_q) inside
				REQ_POSITION: begin
					px_we = x_ok_q;
					py_we = x_ok_q && y_ok_q;
					sts_n = (x_ok_q && y_ok_q) ? STS_POS_OK : STS_NO_POS;
				end
				REQ_ACQUIRE, REQ_RELEASE: begin
					if (!res_ok_q) begin
						sts_n = STS_BAD;
					end else if (type_q == REQ_ACQUIRE) begin
						if (held_cur) begin
							sts_n = own_match ? STS_ALREADY : STS_BUSY;
						end else begin
							sts_n    = STS_RESERVED;
							set_held = 1'b1;
							own_we   = 1'b1;
						end
					end else begin
						if (held_cur && own_match) begin
							sts_n    = STS_RELEASED;
							clr_held = 1'b1;
						end else begin
							sts_n = STS_NOT_OWNER;
						end
					end
				end
				default: begin
					sts_n = STS_BAD;
				end
			endcase
		end
	end

	// Registered table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q  <= '0;
		end else if (cmd.exec) begin
			if (addr_we) count_q <= count_q + 1'b1;
			if (set_held) held_q[lock_idx_q] <= 1'b1;
			if (clr_held) held_q[lock_idx_q] <= 1'b0;
		end
	end

	// Result word and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= sts_n;
			slot_q   <= slot_ext[2:0];
		end
	end

	assign slot_ext   = SXW'(slot_n);
	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_q;

	// Client address table
	crrl_ram #(.WIDTH(32), .DEPTH(MAX_CLIENTS)) u_addr_ram (
		.clk   (clk),
		.we    (cmd.exec && addr_we),
		.waddr (new_slot),
		.wdata (addr_q),
		.raddr (addr_raddr),
		.rdata (addr_rd)
	);

	// Stored positions
	crrl_ram #(.WIDTH(32), .DEPTH(MAX_CLIENTS)) u_posx_ram (
		.clk   (clk),
		.we    (cmd.exec && px_we),
		.waddr (pos_waddr),
		.wdata (px_wdata),
		.raddr (slot_cur),
		.rdata ()
	);

	crrl_ram #(.WIDTH(32), .DEPTH(MAX_CLIENTS)) u_posy_ram (
		.clk   (clk),
		.we    (cmd.exec && py_we),
		.waddr (pos_waddr),
		.wdata (py_wdata),
		.raddr (slot_cur),
		.rdata ()
	);

	// Lock owner table, read at the captured lock index
	crrl_ram #(.WIDTH(SW), .DEPTH(NUM_LOCKS)) u_owner_ram (
		.clk   (clk),
		.we    (cmd.exec && own_we),
		.waddr (lock_idx_q),
		.wdata (slot_cur),
		.raddr (lock_idx_q),
		.rdata (own_rd)
	);

endmodule

FILE: rtl/core/client_registry_and_resource_locks_unit.sv
// Top level of the client registry and resource lock unit.
// One request word is taken when start is high and busy is low. The unit
// searches its client slots one per cycle through the address table RAM
// and holds busy high until the request has executed, so no new request is
// taken while one is in progress. The result word (status, slot_index)
// appears for exactly one cycle with done high, in the cycle in which busy
// drops; the receiver cannot stall it, and a new request may be taken in
// that same cycle.
module client_registry_and_resource_locks_unit
	import crrl_pkg::*;
#(
	parameter int MAX_CLIENTS = 8,
	parameter int NUM_LOCKS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic [31:0]        client_addr,
	input  logic               x_present,
	input  logic signed [31:0] x_value,
	input  logic               y_present,
	input  logic signed [31:0] y_value,
	input  logic               res_present,
	input  logic signed [31:0] res_number,
	output logic               done,
	output logic [3:0]         status,
	output logic [2:0]         slot_index
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	crrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	crrl_dp #(.MAX_CLIENTS(MAX_CLIENTS), .NUM_LOCKS(NUM_LOCKS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.client_addr (client_addr),
		.x_present   (x_present),
		.x_value     (x_value),
		.y_present   (y_present),
		.y_value     (y_value),
		.res_present (res_present),
		.res_number  (res_number),
		.done        (done),
		.status      (status),
		.slot_index  (slot_index)
	);

	// A result word only shows once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted request always occupies the unit next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start");

	// Unknown clients and a full table report slot zero
	a_noslot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STS_UNREG || status == STS_FULL)) |-> (slot_index == 3'd0))
		else $error("nonzero slot for unregistered or full");

	// Status codes stay within the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= STS_BAD))
		else $error("status code out of range");

endmodule
